// ----- hw/rtl/lpps_pkg.sv -----
// Shared types, constants and register codes of the line-position PID steering block.
package lpps_pkg;

   localparam int SENSOR_COUNT_DEF  = 8;
   localparam int WINDOW_LENGTH_DEF = 6;
   localparam int SAMPLE_BITS_DEF   = 12;

   localparam int INPUT_COUNT    = 8;
   localparam int THRESH_PER_REG = 4;
   localparam int CSR_DATA_W     = 48;
   localparam int CSR_INDEX_W    = 3;
   localparam int ERR_W          = 11;
   localparam int POS_OUT_W      = 10;
   localparam int GAIN_W         = 16;
   localparam int SPEED_W        = 8;
   localparam int CORR_W         = 16;
   localparam int POS_STEP       = 100;
   localparam int QUEUE_DEPTH    = 4;
   localparam int RSP_DATA_W     = 48;

   localparam logic [GAIN_W-1:0]    GAIN_P_RST     = 16'd82;
   localparam logic [GAIN_W-1:0]    GAIN_I_RST     = 16'd0;
   localparam logic [GAIN_W-1:0]    GAIN_D_RST     = 16'd1651;
   localparam logic [POS_OUT_W-1:0] TARGET_POS_RST = 10'd400;
   localparam logic [SPEED_W-1:0]   BASE_SPEED_RST = 8'd95;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_THRESH_A   = 3'd0,
      REG_THRESH_B   = 3'd1,
      REG_GAIN_P     = 3'd2,
      REG_GAIN_I     = 3'd3,
      REG_GAIN_D     = 3'd4,
      REG_TARGET_POS = 3'd5,
      REG_BASE_SPEED = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic [POS_OUT_W-1:0]    position;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [SPEED_W-1:0] base_speed;
   } pid_cfg_type;

endpackage

// ----- hw/rtl/lpps_front.sv -----
// Front end: thresholds the sensor frame, tracks polarity and forms position and error.
module lpps_front #(
   parameter int SENSOR_COUNT = lpps_pkg::SENSOR_COUNT_DEF,
   parameter int SAMPLE_BITS  = lpps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         frame_valid,
   output logic                                         frame_ready,
   input  logic [lpps_pkg::INPUT_COUNT*SAMPLE_BITS-1:0] samples,
   input  logic [lpps_pkg::CSR_DATA_W-1:0]              thresholds_a,
   input  logic [lpps_pkg::CSR_DATA_W-1:0]              thresholds_b,
   input  logic [lpps_pkg::POS_OUT_W-1:0]               target_position,
   input  logic                                         queue_full,
   output logic                                         push,
   output lpps_pkg::item_type                           item
);

   localparam int TH_W   = lpps_pkg::THRESH_PER_REG * SAMPLE_BITS;
   localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
   localparam int POS_W  = $clog2(lpps_pkg::POS_STEP * SENSOR_COUNT + 1);
   localparam int DIFF_W = ((POS_W > lpps_pkg::POS_OUT_W) ? POS_W : lpps_pkg::POS_OUT_W) + 1;

   logic [TH_W-1:0]         thr_a_ext;
   logic [TH_W-1:0]         thr_b_ext;
   logic [SENSOR_COUNT-1:0] line;
   logic [CNT_W-1:0]        lines;
   logic [CNT_W-1:0]        count;
   logic [POS_W-1:0]        position;
   logic [DIFF_W-1:0]       diff;
   logic                    polarity_ff;
   logic                    polarity_in;

   assign thr_a_ext = TH_W'(thresholds_a);
   assign thr_b_ext = TH_W'(thresholds_b);

   for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_sensor
      if (i < lpps_pkg::THRESH_PER_REG) begin : g_reg_a
         assign line[i] = !(samples[i*SAMPLE_BITS +: SAMPLE_BITS] >
                            thr_a_ext[i*SAMPLE_BITS +: SAMPLE_BITS]);
      end else if (i < lpps_pkg::INPUT_COUNT) begin : g_reg_b
         assign line[i] = !(samples[i*SAMPLE_BITS +: SAMPLE_BITS] >
            thr_b_ext[(i - lpps_pkg::THRESH_PER_REG)*SAMPLE_BITS +: SAMPLE_BITS]);
      end else begin : g_absent
         // missing sensors read zero against a zero threshold
         assign line[i] = 1'b1;
      end
   end

   always_comb begin
      lines = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         lines = lines + CNT_W'(line[i]);
      end
   end

   always_comb begin
      if (!line[0] && line[SENSOR_COUNT-1]) begin
         polarity_in = 1'b1;
      end else if (line[0] && !line[SENSOR_COUNT-1]) begin
         polarity_in = 1'b0;
      end else begin
         polarity_in = polarity_ff;
      end
   end

   assign count    = polarity_in ? lines : CNT_W'(SENSOR_COUNT) - lines;
   assign position = POS_W'(lpps_pkg::POS_STEP) * POS_W'(count);
   assign diff     = DIFF_W'(target_position) - DIFF_W'(position);

   assign frame_ready   = !queue_full;
   assign push          = frame_valid && frame_ready;
   assign item.err      = diff[lpps_pkg::ERR_W-1:0];
   assign item.position = lpps_pkg::POS_OUT_W'(position);

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff <= 1'b1;
      end else if (push) begin
         polarity_ff <= polarity_in;
      end
   end

endmodule

// ----- hw/rtl/lpps_queue.sv -----
// Short queue that decouples the front end from the PID back end.
module lpps_queue #(
   parameter int DEPTH = lpps_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpps_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output lpps_pkg::item_type pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpps_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/lpps_back.sv -----
// Back end: error window, PID products, correction and wheel speed clamps.
module lpps_back #(
   parameter int WINDOW_LENGTH = lpps_pkg::WINDOW_LENGTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_pop,
   input  lpps_pkg::item_type               in_item,
   input  lpps_pkg::pid_cfg_type            cfg,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [lpps_pkg::SPEED_W-1:0]     left_drive,
   output logic [lpps_pkg::SPEED_W-1:0]     right_drive,
   output logic [lpps_pkg::CORR_W-1:0]      correction,
   output logic [lpps_pkg::POS_OUT_W-1:0]   line_position
);

   localparam int HIST_LEN = WINDOW_LENGTH - 1;
   localparam int ERR_W    = lpps_pkg::ERR_W;
   localparam int GAIN_W   = lpps_pkg::GAIN_W;
   localparam int INT_W    = ERR_W + $clog2(WINDOW_LENGTH);
   localparam int PP_W     = GAIN_W + 1 + ERR_W;
   localparam int PI_W     = GAIN_W + 1 + INT_W;
   localparam int PD_W     = GAIN_W + 2 + ERR_W;
   localparam int ACC_W    = GAIN_W + INT_W + 3;
   localparam int Q_W      = ACC_W - 8;
   localparam int CORR_W   = lpps_pkg::CORR_W;
   localparam int SPD_W    = CORR_W + 2;
   localparam int SPEED_W  = lpps_pkg::SPEED_W;

   localparam logic signed [Q_W-1:0]   CORR_MAX  = Q_W'(32767);
   localparam logic signed [Q_W-1:0]   CORR_MIN  = -Q_W'(32768);
   localparam logic signed [SPD_W-1:0] SPEED_TOP = SPD_W'(255);

   // error window taps, newest first, and their running sum
   logic signed [ERR_W-1:0] hist_ff [HIST_LEN];
   logic signed [INT_W-1:0] sum_ff;
   logic signed [INT_W-1:0] sum_in;
   logic signed [INT_W-1:0] integ;
   logic signed [ERR_W:0]   deriv;
   logic signed [GAIN_W:0]  gp;
   logic signed [GAIN_W:0]  gi;
   logic signed [GAIN_W:0]  gd;
   logic signed [PP_W-1:0]  prod_p_in;
   logic signed [PI_W-1:0]  prod_i_in;
   logic signed [PD_W-1:0]  prod_d_in;

   logic                            a_valid_ff;
   logic                            a_advance;
   logic signed [PP_W-1:0]          prod_p_ff;
   logic signed [PI_W-1:0]          prod_i_ff;
   logic signed [PD_W-1:0]          prod_d_ff;
   logic [lpps_pkg::POS_OUT_W-1:0]  pos_a_ff;

   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_adj;
   logic signed [Q_W-1:0]   quot;
   logic signed [CORR_W-1:0] corr;
   logic signed [SPD_W-1:0] base_x;
   logic signed [SPD_W-1:0] left_raw;
   logic signed [SPD_W-1:0] right_raw;
   logic [SPEED_W-1:0]      left_sat;
   logic [SPEED_W-1:0]      right_sat;

   logic                            b_valid_ff;
   logic                            b_advance;
   logic [SPEED_W-1:0]              left_ff;
   logic [SPEED_W-1:0]              right_ff;
   logic [CORR_W-1:0]               corr_ff;
   logic [lpps_pkg::POS_OUT_W-1:0]  pos_b_ff;

   // stage handshakes: advance when the stage ahead is empty or draining
   assign b_advance = !b_valid_ff || out_ready;
   assign a_advance = !a_valid_ff || b_advance;
   assign in_pop    = in_valid && a_advance;

   assign integ  = INT_W'(in_item.err) + sum_ff;
   assign deriv  = (ERR_W+1)'(in_item.err) - (ERR_W+1)'(hist_ff[0]);
   assign sum_in = sum_ff + INT_W'(in_item.err) - INT_W'(hist_ff[HIST_LEN-1]);

   assign gp = $signed({1'b0, cfg.gain_p});
   assign gi = $signed({1'b0, cfg.gain_i});
   assign gd = $signed({1'b0, cfg.gain_d});

   assign prod_p_in = gp * in_item.err;
   assign prod_i_in = gi * integ;
   assign prod_d_in = gd * deriv;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         for (int k = 0; k < HIST_LEN; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (in_pop) begin
         sum_ff     <= sum_in;
         hist_ff[0] <= in_item.err;
         for (int k = 1; k < HIST_LEN; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
         pos_a_ff  <= in_item.position;
      end
   end

   // divide by 256 rounding toward zero: bias negative sums by 255 first
   assign acc     = prod_p_ff + prod_i_ff + prod_d_ff;
   assign acc_adj = acc + $signed({{(ACC_W-8){1'b0}}, {8{acc[ACC_W-1]}}});
   assign quot    = acc_adj[ACC_W-1:8];

   always_comb begin
      if (quot > CORR_MAX) begin
         corr = CORR_W'(CORR_MAX);
      end else if (quot < CORR_MIN) begin
         corr = CORR_W'(CORR_MIN);
      end else begin
         corr = quot[CORR_W-1:0];
      end
   end

   assign base_x    = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.base_speed});
   assign left_raw  = base_x - corr;
   assign right_raw = base_x + corr;

   always_comb begin
      if (left_raw[SPD_W-1]) begin
         left_sat = '0;
      end else if (left_raw > SPEED_TOP) begin
         left_sat = '1;
      end else begin
         left_sat = left_raw[SPEED_W-1:0];
      end
      if (right_raw[SPD_W-1]) begin
         right_sat = '0;
      end else if (right_raw > SPEED_TOP) begin
         right_sat = '1;
      end else begin
         right_sat = right_raw[SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_advance && a_valid_ff) begin
         left_ff  <= left_sat;
         right_ff <= right_sat;
         corr_ff  <= corr;
         pos_b_ff <= pos_a_ff;
      end
   end

   assign out_valid     = b_valid_ff;
   assign left_drive    = left_ff;
   assign right_drive   = right_ff;
   assign correction    = corr_ff;
   assign line_position = pos_b_ff;

endmodule

// ----- hw/rtl/line_position_pid_steering.sv -----
// Line-position PID steering: takes one frame of eight reflectance samples per
// word on req_ and returns one word on rsp_ with the two wheel drives, the PID
// correction and the line position. A new frame is taken every clock cycle while
// the queue has room; a frame's result passes the queue write, the product stage
// and the correction stage before it leaves on rsp_. A four-word queue sits
// between the thresholding front end and the PID back end, so req_tready drops
// only after the result side has stalled long enough to fill it. Configuration
// words on csr_ are taken on any cycle and should be written only while idle.
module line_position_pid_steering #(
   parameter int SENSOR_COUNT  = lpps_pkg::SENSOR_COUNT_DEF,
   parameter int WINDOW_LENGTH = lpps_pkg::WINDOW_LENGTH_DEF,
   parameter int SAMPLE_BITS   = lpps_pkg::SAMPLE_BITS_DEF,
   localparam int REQ_DATA_W   = ((lpps_pkg::INPUT_COUNT * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // sample_0 .. sample_7, SAMPLE_BITS each, from the low bits up
   input  logic [REQ_DATA_W-1:0]                req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // left_drive[7:0], right_drive[15:8], correction[31:16], line_position[41:32]
   output logic [lpps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lpps_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SAMPLES_W = lpps_pkg::INPUT_COUNT * SAMPLE_BITS;
   localparam int PAD_W     = lpps_pkg::RSP_DATA_W - 2*lpps_pkg::SPEED_W
                              - lpps_pkg::CORR_W - lpps_pkg::POS_OUT_W;

   logic [lpps_pkg::CSR_DATA_W-1:0] thresh_a_ff;
   logic [lpps_pkg::CSR_DATA_W-1:0] thresh_b_ff;
   logic [lpps_pkg::POS_OUT_W-1:0]  target_ff;
   lpps_pkg::pid_cfg_type           cfg_ff;

   logic                            push;
   logic                            queue_full;
   logic                            queue_empty;
   logic                            pop;
   lpps_pkg::item_type              push_item;
   lpps_pkg::item_type              pop_item;

   logic [lpps_pkg::SPEED_W-1:0]    left_drive;
   logic [lpps_pkg::SPEED_W-1:0]    right_drive;
   logic [lpps_pkg::CORR_W-1:0]     correction;
   logic [lpps_pkg::POS_OUT_W-1:0]  line_position;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_a_ff       <= '0;
         thresh_b_ff       <= '0;
         target_ff         <= lpps_pkg::TARGET_POS_RST;
         cfg_ff.gain_p     <= lpps_pkg::GAIN_P_RST;
         cfg_ff.gain_i     <= lpps_pkg::GAIN_I_RST;
         cfg_ff.gain_d     <= lpps_pkg::GAIN_D_RST;
         cfg_ff.base_speed <= lpps_pkg::BASE_SPEED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lpps_pkg::REG_THRESH_A:   thresh_a_ff       <= csr_data;
            lpps_pkg::REG_THRESH_B:   thresh_b_ff       <= csr_data;
            lpps_pkg::REG_GAIN_P:     cfg_ff.gain_p     <= csr_data[lpps_pkg::GAIN_W-1:0];
            lpps_pkg::REG_GAIN_I:     cfg_ff.gain_i     <= csr_data[lpps_pkg::GAIN_W-1:0];
            lpps_pkg::REG_GAIN_D:     cfg_ff.gain_d     <= csr_data[lpps_pkg::GAIN_W-1:0];
            lpps_pkg::REG_TARGET_POS: target_ff         <= csr_data[lpps_pkg::POS_OUT_W-1:0];
            lpps_pkg::REG_BASE_SPEED: cfg_ff.base_speed <= csr_data[lpps_pkg::SPEED_W-1:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   lpps_front #(
      .SENSOR_COUNT (SENSOR_COUNT),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .frame_valid     (req_tvalid),
      .frame_ready     (req_tready),
      .samples         (req_tdata[SAMPLES_W-1:0]),
      .thresholds_a    (thresh_a_ff),
      .thresholds_b    (thresh_b_ff),
      .target_position (target_ff),
      .queue_full      (queue_full),
      .push            (push),
      .item            (push_item)
   );

   lpps_queue #(
      .DEPTH (lpps_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   lpps_back #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (!queue_empty),
      .in_pop        (pop),
      .in_item       (pop_item),
      .cfg           (cfg_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .left_drive    (left_drive),
      .right_drive   (right_drive),
      .correction    (correction),
      .line_position (line_position)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, line_position, correction, right_drive, left_drive};

endmodule

// ----- tb/line_position_pid_steering_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: sensor frames and register settings against a steering predictor.
module line_position_pid_steering_tb;

   localparam int INPUT_COUNT    = lpps_pkg::INPUT_COUNT;
   localparam int THRESH_PER_REG = lpps_pkg::THRESH_PER_REG;
   localparam int CSR_INDEX_W    = lpps_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W     = lpps_pkg::CSR_DATA_W;
   localparam int RSP_DATA_W     = lpps_pkg::RSP_DATA_W;
   localparam int SPEED_W        = lpps_pkg::SPEED_W;
   localparam int CORR_W         = lpps_pkg::CORR_W;
   localparam int POS_OUT_W      = lpps_pkg::POS_OUT_W;
   localparam int GAIN_W         = lpps_pkg::GAIN_W;
   localparam int ERR_W          = lpps_pkg::ERR_W;
   localparam int POS_STEP       = lpps_pkg::POS_STEP;

   localparam int SAMPLE_W    = lpps_pkg::SAMPLE_BITS_DEF;
   localparam int FRAME_W     = ((INPUT_COUNT * SAMPLE_W + 7) / 8) * 8;
   localparam int HIST_DEPTH  = lpps_pkg::WINDOW_LENGTH_DEF - 1;
   localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
   localparam int IDLE_PCT    = 27;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [SPEED_W-1:0]       left_drive;
      logic [SPEED_W-1:0]       right_drive;
      logic signed [CORR_W-1:0] correction;
      logic [POS_OUT_W-1:0]     line_position;
   } steer_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [FRAME_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   line_position_pid_steering dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // shadow registers and state of the steering loop
   logic [CSR_DATA_W-1:0] thresh_a, thresh_b;
   logic [GAIN_W-1:0]     kp, ki, kd;
   logic [POS_OUT_W-1:0]  target;
   logic [SPEED_W-1:0]    base;
   bit                    polarity;
   int                    err_hist [HIST_DEPTH];

   logic [FRAME_W-1:0] frame_q [$];
   steer_type          drive_q [$];
   int                 failures = 0;
   int                 cycles = 0;
   bit                 steady = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [SAMPLE_W-1:0] thr_of(int i);
      if (i < THRESH_PER_REG) return thresh_a[i*SAMPLE_W +: SAMPLE_W];
      return thresh_b[(i-THRESH_PER_REG)*SAMPLE_W +: SAMPLE_W];
   endfunction

   function automatic logic [SPEED_W-1:0] clamp_speed(longint v);
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return v[SPEED_W-1:0];
   endfunction

   function automatic steer_type steer_predict(logic [FRAME_W-1:0] frame);
      steer_type               r;
      int                      lines;
      int                      pos;
      logic signed [ERR_W-1:0] err;
      int                      integ;
      int                      deriv;
      longint                  acc;
      longint                  corr;
      bit                      is_line, left_line, right_line;
      lines = 0;
      left_line = 1'b0;
      right_line = 1'b0;
      for (int i = 0; i < INPUT_COUNT; i++) begin
         is_line = frame[i*SAMPLE_W +: SAMPLE_W] <= thr_of(i);
         if (i == 0) left_line = is_line;
         if (i == INPUT_COUNT - 1) right_line = is_line;
         lines += int'(is_line);
      end
      // edges disagree: the lone line edge sets the polarity
      if (!left_line && right_line) polarity = 1'b1;
      else if (left_line && !right_line) polarity = 1'b0;
      pos = POS_STEP * (polarity ? lines : INPUT_COUNT - lines);
      err = ERR_W'(int'(target) - pos);
      integ = err;
      for (int k = 0; k < HIST_DEPTH; k++) integ += err_hist[k];
      deriv = err - err_hist[0];
      for (int k = HIST_DEPTH - 1; k > 0; k--) err_hist[k] = err_hist[k-1];
      err_hist[0] = err;
      acc = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * deriv;
      corr = acc / 256;
      if (corr > 32767) corr = 32767;
      if (corr < -32768) corr = -32768;
      r.left_drive = clamp_speed(longint'(base) - corr);
      r.right_drive = clamp_speed(longint'(base) + corr);
      r.correction = corr[CORR_W-1:0];
      r.line_position = pos[POS_OUT_W-1:0];
      return r;
   endfunction

   function automatic void cfg_apply(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         lpps_pkg::REG_THRESH_A:   thresh_a = data;
         lpps_pkg::REG_THRESH_B:   thresh_b = data;
         lpps_pkg::REG_GAIN_P:     kp = data[GAIN_W-1:0];
         lpps_pkg::REG_GAIN_I:     ki = data[GAIN_W-1:0];
         lpps_pkg::REG_GAIN_D:     kd = data[GAIN_W-1:0];
         lpps_pkg::REG_TARGET_POS: target = data[POS_OUT_W-1:0];
         lpps_pkg::REG_BASE_SPEED: base = data[SPEED_W-1:0];
         default: ;
      endcase
   endfunction

   // line sensors read 0, the rest full scale
   function automatic logic [FRAME_W-1:0] extreme_frame(logic [INPUT_COUNT-1:0] mask);
      logic [FRAME_W-1:0] f;
      f = '0;
      for (int i = 0; i < INPUT_COUNT; i++)
         f[i*SAMPLE_W +: SAMPLE_W] = mask[i] ? '0 : SAMPLE_MAX[SAMPLE_W-1:0];
      return f;
   endfunction

   // place each sample on the chosen side of its threshold; exact hugs the threshold
   function automatic logic [FRAME_W-1:0] frame_from_mask(logic [INPUT_COUNT-1:0] mask, bit exact);
      logic [FRAME_W-1:0] f;
      int                 thr;
      int                 s;
      f = '0;
      for (int i = 0; i < INPUT_COUNT; i++) begin
         thr = int'(thr_of(i));
         if (mask[i]) s = exact ? thr : int'($urandom_range(thr, 0));
         else if (thr == SAMPLE_MAX) s = SAMPLE_MAX;
         else s = exact ? thr + 1 : int'($urandom_range(SAMPLE_MAX, thr + 1));
         f[i*SAMPLE_W +: SAMPLE_W] = s[SAMPLE_W-1:0];
      end
      return f;
   endfunction

   function automatic logic [FRAME_W-1:0] random_frame();
      logic [FRAME_W-1:0]     f;
      logic [INPUT_COUNT-1:0] mask;
      int                     pick, width, start;
      pick = int'($urandom_range(99));
      if (pick < 70) begin
         // a narrow line somewhere under the array, dark or light
         width = int'($urandom_range(3, 1));
         start = int'($urandom_range(INPUT_COUNT - width, 0));
         mask = '0;
         for (int i = 0; i < width; i++) mask[start + i] = 1'b1;
         if ($urandom_range(99) < 30) mask = ~mask;
         return frame_from_mask(mask, $urandom_range(9) == 0);
      end
      if (pick < 85) return frame_from_mask(INPUT_COUNT'($urandom_range(255)), 1'b0);
      for (int i = 0; i < FRAME_W; i += 32) f[i +: 32] = $urandom;
      return f;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_thresholds();
      logic [CSR_DATA_W-1:0] t;
      for (int i = 0; i < THRESH_PER_REG; i++)
         t[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'($urandom_range(SAMPLE_MAX));
      return t;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_gain();
      if ($urandom_range(3) == 0) return CSR_DATA_W'($urandom_range(65535));
      return CSR_DATA_W'($urandom_range(2047));
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_apply(idx, data);
   endtask

   task automatic write_all(logic [CSR_DATA_W-1:0] ta, logic [CSR_DATA_W-1:0] tb,
                            logic [CSR_DATA_W-1:0] p, logic [CSR_DATA_W-1:0] i,
                            logic [CSR_DATA_W-1:0] d, logic [CSR_DATA_W-1:0] tgt,
                            logic [CSR_DATA_W-1:0] spd);
      write_reg(lpps_pkg::REG_THRESH_A, ta);
      write_reg(lpps_pkg::REG_THRESH_B, tb);
      write_reg(lpps_pkg::REG_GAIN_P, p);
      write_reg(lpps_pkg::REG_GAIN_I, i);
      write_reg(lpps_pkg::REG_GAIN_D, d);
      write_reg(lpps_pkg::REG_TARGET_POS, tgt);
      write_reg(lpps_pkg::REG_BASE_SPEED, spd);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (frame_q.size() != 0 || req_tvalid || drive_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_random(int n);
      repeat (n) frame_q.push_back(random_frame());
      wait_drained();
   endtask

   // driver: hold a word until taken, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) drive_q.push_back(steer_predict(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (frame_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_tdata <= frame_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result word against the oldest expected drive
   always @(posedge clock) begin
      steer_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            failures++;
         end else begin
            e = drive_q.pop_front();
            if (rsp_tdata[7:0] !== e.left_drive) begin
               $error("left_drive: expected %0d, got %0d", e.left_drive, rsp_tdata[7:0]);
               failures++;
            end
            if (rsp_tdata[15:8] !== e.right_drive) begin
               $error("right_drive: expected %0d, got %0d", e.right_drive, rsp_tdata[15:8]);
               failures++;
            end
            if (rsp_tdata[31:16] !== e.correction) begin
               $error("correction: expected %0d, got %0d", e.correction,
                      $signed(rsp_tdata[31:16]));
               failures++;
            end
            if (rsp_tdata[41:32] !== e.line_position) begin
               $error("line_position: expected %0d, got %0d", e.line_position,
                      rsp_tdata[41:32]);
               failures++;
            end
         end
      end
      rsp_tready <= !reset && (steady || $urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      thresh_a = '0;
      thresh_b = '0;
      kp = lpps_pkg::GAIN_P_RST;
      ki = lpps_pkg::GAIN_I_RST;
      kd = lpps_pkg::GAIN_D_RST;
      target = lpps_pkg::TARGET_POS_RST;
      base = lpps_pkg::BASE_SPEED_RST;
      polarity = 1'b1;
      foreach (err_hist[k]) err_hist[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero thresholds, so only a zero sample reads as line
      frame_q.push_back(extreme_frame(8'hFF));
      frame_q.push_back(extreme_frame(8'h00));
      frame_q.push_back(extreme_frame(8'h01));
      frame_q.push_back(extreme_frame(8'h80));
      frame_q.push_back(extreme_frame(8'h81));
      frame_q.push_back(extreme_frame(8'h7E));
      frame_q.push_back({INPUT_COUNT{12'hAAA}});
      frame_q.push_back({INPUT_COUNT{12'h555}});
      run_random(40);

      // mid thresholds: walk the polarity cases and the at-threshold boundary
      write_all({THRESH_PER_REG{12'h800}}, {THRESH_PER_REG{12'h7FF}}, 200, 10, 900, 400, 128);
      frame_q.push_back(frame_from_mask(8'hFF, 1'b1));
      frame_q.push_back(frame_from_mask(8'h00, 1'b1));
      frame_q.push_back(frame_from_mask(8'h18, 1'b0));
      frame_q.push_back(frame_from_mask(8'h80, 1'b0));
      frame_q.push_back(frame_from_mask(8'hC0, 1'b0));
      frame_q.push_back(frame_from_mask(8'h81, 1'b1));
      frame_q.push_back(frame_from_mask(8'h01, 1'b0));
      frame_q.push_back(frame_from_mask(8'h03, 1'b0));
      frame_q.push_back(frame_from_mask(8'hE7, 1'b0));
      frame_q.push_back(frame_from_mask(8'h7E, 1'b1));
      frame_q.push_back(frame_from_mask(8'h3C, 1'b0));
      frame_q.push_back(frame_from_mask(8'h00, 1'b0));
      run_random(100);

      // full-scale gains and oversized writes; drop the masked bits; no idling
      steady = 1'b1;
      write_all(random_thresholds(), random_thresholds(), '1, '1, '1, '1, '1);
      write_reg(REG_UNUSED, random_thresholds());
      run_random(100);
      steady = 1'b0;

      // zero gains, setpoint and speed, then full P gain and speed; thresholds at both ends
      write_all({THRESH_PER_REG{12'hFFF}}, '0, 0, 0, 0, 0, 0);
      run_random(50);
      write_all('0, {THRESH_PER_REG{12'hFFF}}, 65535, 0, 0, 0, 255);
      run_random(50);

      repeat (3) begin
         write_all(random_thresholds(), random_thresholds(), random_gain(), random_gain(),
                   random_gain(), CSR_DATA_W'($urandom_range(800)),
                   CSR_DATA_W'($urandom_range(255)));
         write_reg(REG_UNUSED, random_thresholds());
         run_random(90);
      end

      if (drive_q.size() != 0) begin
         $error("%0d results never arrived", drive_q.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
